FILE: src/ice_pkg.sv
// Shared types and constants for the implication closure engine.
// No dependencies; ice_engine and the top level import this package.
`default_nettype none

package ice_pkg;

    localparam int SET_W       = 64;
    localparam int IDX_W       = 6;
    localparam int CFG_W       = 7;
    localparam int PASS_W      = 7;
    localparam int ATTR_DEF    = 64;
    localparam int RULES_DEF   = 64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] rule_index;
        logic [SET_W-1:0] premise;
        logic [SET_W-1:0] conclusion;
        logic [SET_W-1:0] query_set;
    } in_item_t;

    typedef struct packed {
        logic [SET_W-1:0]  closure_set;
        logic [PASS_W-1:0] pass_count;
    } out_item_t;

    // Engine status seen by the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_stat_t;

endpackage

`default_nettype wire

FILE: src/ice_rule_mem.sv
// Rule table: one premise/conclusion pair per slot, one write and one read port.
// Read data is registered. Does not depend on ice_pkg.
`default_nettype none

module ice_rule_mem #(
    parameter int RULES      = 64,
    parameter int ATTRIBUTES = 64,
    localparam int AW        = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [ATTRIBUTES-1:0] wr_premise,
    input  wire logic [ATTRIBUTES-1:0] wr_conclusion,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [ATTRIBUTES-1:0] rd_premise,
    output logic      [ATTRIBUTES-1:0] rd_conclusion
);

    logic [2*ATTRIBUTES-1:0] mem [RULES];
    logic [2*ATTRIBUTES-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_premise, wr_conclusion};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_premise    = rd_data_reg[2*ATTRIBUTES-1:ATTRIBUTES];
    assign rd_conclusion = rd_data_reg[ATTRIBUTES-1:0];

endmodule

`default_nettype wire

FILE: src/ice_engine.sv
// Closure sequencer: streams rule reads, tests one premise per cycle in a scan
// against the working set and repeats scans until one adds nothing. Depends on ice_pkg.
`default_nettype none

module ice_engine #(
    parameter int RULES      = 64,
    parameter int ATTRIBUTES = 64,
    localparam int AW        = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ATTRIBUTES-1:0]      query,
    input  wire logic [ice_pkg::CFG_W-1:0]  rule_count,
    output logic                            rd_en,
    output logic      [AW-1:0]              rd_addr,
    input  wire logic [ATTRIBUTES-1:0]      rd_premise,
    input  wire logic [ATTRIBUTES-1:0]      rd_conclusion,
    output ice_pkg::eng_stat_t              stat,
    input  wire logic                       ack,
    output logic      [ATTRIBUTES-1:0]      result_set,
    output logic      [ice_pkg::PASS_W-1:0] result_passes
);

    import ice_pkg::*;

    localparam int CntW = $clog2(RULES + 1);
    localparam int ExtW = (CntW > CFG_W) ? CntW : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [ATTRIBUTES-1:0] ws_reg, ws_next;
    logic [PASS_W-1:0]     pass_reg, pass_next;
    logic                  chg_reg, chg_next;
    logic [CntW-1:0]       n_reg, n_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  issue_reg, issue_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic                  eval_last_reg, eval_last_next;

    logic [ExtW-1:0]       rc_ext;
    logic [CntW-1:0]       n_lim;
    logic                  last_addr;
    logic                  hit;
    logic [ATTRIBUTES-1:0] ws_upd;
    logic                  grew;

    // Counts above the table size use every slot.
    assign rc_ext = ExtW'(rule_count);
    assign n_lim  = (rc_ext > ExtW'(RULES)) ? CntW'(RULES) : CntW'(rc_ext);

    assign last_addr = (CntW'(addr_reg) == n_reg - CntW'(1));

    // The shared test unit: subset check and merge of one rule.
    assign hit    = ((rd_premise & ~ws_reg) == '0);
    assign ws_upd = hit ? (ws_reg | rd_conclusion) : ws_reg;
    assign grew   = (ws_upd != ws_reg);

    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        pass_next      = pass_reg;
        chg_next       = chg_reg;
        n_next         = n_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        eval_vld_next  = 1'b0;
        eval_last_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ws_next    = query;
                    n_next     = n_lim;
                    chg_next   = 1'b0;
                    addr_next  = '0;
                    if (n_lim == '0)
                    begin
                        pass_next  = PASS_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        pass_next  = '0;
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    addr_next      = addr_reg + AW'(1);
                    eval_vld_next  = 1'b1;
                    eval_last_next = last_addr;
                    if (last_addr)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (eval_vld_reg)
                begin
                    ws_next  = ws_upd;
                    chg_next = chg_reg | grew;
                    if (eval_last_reg)
                    begin
                        pass_next = pass_reg + PASS_W'(1);
                        if (chg_reg | grew)
                        begin
                            // Another scan from slot zero with the grown set.
                            issue_next = 1'b1;
                            addr_next  = '0;
                            chg_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= '0;
            chg_reg       <= 1'b0;
            issue_reg     <= 1'b0;
            eval_vld_reg  <= 1'b0;
            eval_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            chg_reg       <= chg_next;
            issue_reg     <= issue_next;
            eval_vld_reg  <= eval_vld_next;
            eval_last_reg <= eval_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        n_reg    <= n_next;
        addr_reg <= addr_next;
    end

    assign rd_en         = (state_reg == ST_SCAN) && issue_reg;
    assign rd_addr       = addr_reg;
    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.done     = (state_reg == ST_DONE);
    assign result_set    = ws_reg;
    assign result_passes = pass_reg;

`ifndef SYNTH
    // Rule evaluation only happens inside a scan.
    a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_vld_reg |-> (state_reg == ST_SCAN))
        else $error("rule evaluation outside a scan");

    // Within a scan the working set only gains bits.
    a_ws_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && eval_vld_reg)
        |=> ((ws_reg & $past(ws_reg)) == $past(ws_reg)))
        else $error("working set lost bits during a scan");

    // A finished closure reports between one and ATTRIBUTES+1 scans.
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE)
        |-> (pass_reg != '0 && pass_reg <= PASS_W'(ATTRIBUTES + 1)))
        else $error("scan count out of range");

    // The issue side never runs ahead of a pending last evaluation.
    a_issue_stop: assert property (@(posedge clk) disable iff (!rst_n)
        eval_last_reg |-> !issue_reg)
        else $error("read issued while last rule of a scan pending");
`endif

endmodule

`default_nettype wire

FILE: src/implication_closure_engine_top.sv
// Top level of the implication closure engine: configuration register, rule table,
// closure sequencer and output register. Depends on ice_pkg, ice_rule_mem, ice_engine.
//
// Usage:
//   The input channel (in_valid/in_stall/in_data) carries write and close
//   transactions. A write transaction stores one rule and yields no result;
//   a slot index at or beyond RULES is dropped. A close transaction returns
//   one result on the output channel (out_valid/out_stall/out_data): the
//   closure and the number of scans. In each scan the n rules in use
//   (rule_count, capped at RULES) are read through the single read port of the
//   rule table, one rule per cycle, and each rule is tested and merged as it
//   arrives. in_stall stays high while a close is in progress.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next transaction may already be accepted, and a further finished
//   result waits in the sequencer until the register frees up. rule_count is
//   to be written through cfg_valid/cfg_ready only while the block is idle, by
//   the user; the block does not enforce it. Reset clears rule_count, the
//   working set and all control state; the rule table is undefined until written.
`default_nettype none

module implication_closure_engine_top #(
    parameter int ATTRIBUTES = ice_pkg::ATTR_DEF,
    parameter int RULES      = ice_pkg::RULES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire ice_pkg::in_item_t         in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output ice_pkg::out_item_t             out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ice_pkg::CFG_W-1:0] cfg_data
);

    import ice_pkg::*;

    localparam int AW = (RULES > 1) ? $clog2(RULES) : 1;

    logic [CFG_W-1:0]      rule_count_reg;
    logic                  out_valid_reg;
    logic [SET_W-1:0]      out_set_reg;
    logic [PASS_W-1:0]     out_pass_reg;

    logic                  in_accept;
    logic                  wr_en;
    logic                  start;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [ATTRIBUTES-1:0] rd_premise;
    logic [ATTRIBUTES-1:0] rd_conclusion;
    eng_stat_t             stat;
    logic                  load;
    logic [ATTRIBUTES-1:0] result_set;
    logic [PASS_W-1:0]     result_passes;

    assign cfg_ready = 1'b1;
    assign in_stall  = stat.busy;
    assign in_accept = in_valid && !in_stall;
    assign wr_en     = in_accept && (in_data.cmd == CMD_WRITE)
                       && (32'(in_data.rule_index) < RULES);
    assign start     = in_accept && (in_data.cmd == CMD_CLOSE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rule_count_reg <= cfg_data;
        end
    end

    ice_rule_mem #(
        .RULES      (RULES),
        .ATTRIBUTES (ATTRIBUTES)
    ) u_mem (
        .clk           (clk),
        .wr_en         (wr_en),
        .wr_addr       (AW'(in_data.rule_index)),
        .wr_premise    (in_data.premise[ATTRIBUTES-1:0]),
        .wr_conclusion (in_data.conclusion[ATTRIBUTES-1:0]),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_premise    (rd_premise),
        .rd_conclusion (rd_conclusion)
    );

    ice_engine #(
        .RULES      (RULES),
        .ATTRIBUTES (ATTRIBUTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .query         (in_data.query_set[ATTRIBUTES-1:0]),
        .rule_count    (rule_count_reg),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_premise    (rd_premise),
        .rd_conclusion (rd_conclusion),
        .stat          (stat),
        .ack           (load),
        .result_set    (result_set),
        .result_passes (result_passes)
    );

    // The output register takes a finished result when it is empty or draining.
    assign load = stat.done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_set_reg  <= SET_W'(result_set);
            out_pass_reg <= result_passes;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_data.closure_set = out_set_reg;
    assign out_data.pass_count  = out_pass_reg;

endmodule

`default_nettype wire
